>>> rtl/core/hldb_pkg.sv
// Shared types, codes and saturating helpers for the Haar level bounds block.
// Depends on nothing; imported by every module under rtl/core.
package hldb_pkg;

    localparam int FRAC = 24;

    localparam logic [2:0] OP_QUERY = 3'd0;
    localparam logic [2:0] OP_LEVEL = 3'd1;
    localparam logic [2:0] OP_CAND  = 3'd2;
    localparam logic [2:0] OP_SIGN  = 3'd3;
    localparam logic [2:0] OP_COEF  = 3'd4;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // One query store entry: sign bit, square and saturated magnitude
    typedef struct packed {
        logic        sign;
        logic [63:0] sq;
        logic [62:0] mag;
    } q_entry_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63]))
            return a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a - b;
        if ((a[63] != b[63]) && (r[63] != a[63]))
            return a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // Truncate a quarter of w to a whole number, keeping its sign
    function automatic logic signed [63:0] quarter_int(input logic signed [63:0] w);
        logic [63:0] m;
        m = (mag64(w) >> 2) & ~64'h0000_0000_00FF_FFFF;
        return w[63] ? (64'd0 - m) : m;
    endfunction

endpackage

>>> rtl/core/hldb_mul.sv
// Shared Q40.24 saturating multiplier: four 32x32 partial products, one a cycle.
// Depends on hldb_pkg.
module hldb_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    output logic                done,
    output logic signed [63:0]  result
);
    import hldb_pkg::*;

    logic [63:0]  ua_reg, ua_next, ub_reg, ub_next;
    logic         neg_reg, neg_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         run_reg, run_next, fin_reg, fin_next, done_reg, done_next;
    logic signed [63:0] result_reg, result_next;

    logic [31:0]  op_a, op_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  lim, m;

    // Pick the partial product for this step
    always_comb
    begin
        op_a  = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        op_b  = (cnt_reg == 2'd1 || cnt_reg == 2'd3) ? ub_reg[63:32] : ub_reg[31:0];
        pp    = op_a * op_b;
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
    end

    // Advance the product and saturate it on the finishing step
    always_comb
    begin
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        fin_next    = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        lim         = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        m           = acc_reg[87:24];
        if (acc_reg[127:88] != 40'd0 || m > lim)
            m = lim;
        if (start)
        begin
            ua_next  = mag64(a);
            ub_next  = mag64(b);
            neg_next = a[63] ^ b[63];
            acc_next = 128'd0;
            cnt_next = 2'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            result_next = neg_reg ? (64'd0 - m) : m;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/hldb_sqrt.sv
// Restoring square root of x * 2^24, one result bit a cycle; a negative or zero x gives root 0.
// Depends on hldb_pkg.
module hldb_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  x,
    output logic                done,
    output logic [43:0]         root
);
    import hldb_pkg::*;

    logic [87:0] rad_reg, rad_next;
    logic [47:0] rem_reg, rem_next;
    logic [43:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next, done_reg, done_next;

    logic [47:0] rem_s, trial;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_s     = {rem_reg[45:0], rad_reg[87:86]};
        trial     = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = {x[63:0], 24'd0};
            rem_next  = 48'd0;
            root_next = 44'd0;
            cnt_next  = 6'd43;
            if (x[63] || x == 64'sd0)
                done_next = 1'b1;
            else
                run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[85:0], 2'b00};
            if (rem_s >= trial)
            begin
                rem_next  = rem_s - trial;
                root_next = {root_reg[42:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_s;
                root_next = {root_reg[42:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/core/hldb_store.sv
// Query entry memory and candidate sign word memory, one registered read port.
// Depends on hldb_pkg for the entry type.
module hldb_store #(
    parameter int SIZE = 256
) (
    input  logic                 clk,
    input  logic                 q_we,
    input  logic [7:0]           q_waddr,
    input  hldb_pkg::q_entry_t   q_wdata,
    input  logic                 s_we,
    input  logic [7:0]           s_waddr,
    input  logic [31:0]          s_wdata,
    input  logic [9:0]           rd_addr,
    output logic [62:0]          rd_mag,
    output logic signed [63:0]   rd_sq,
    output logic                 rd_agree
);
    import hldb_pkg::*;

    localparam int AW  = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int SW  = (SIZE + 31) / 32;
    localparam int SWW = (SW > 1) ? $clog2(SW) : 1;

    q_entry_t    qmem [SIZE];
    logic [31:0] smem [SW];

    q_entry_t    q_rd_reg;
    logic [31:0] s_rd_reg;
    logic [4:0]  bit_reg;

    // Write on request, read every cycle
    always_ff @(posedge clk)
    begin
        if (q_we)
            qmem[AW'(q_waddr)] <= q_wdata;
        if (s_we)
            smem[SWW'(s_waddr)] <= s_wdata;
        q_rd_reg <= qmem[AW'(rd_addr)];
        s_rd_reg <= smem[SWW'(rd_addr >> 5)];
        bit_reg  <= rd_addr[4:0];
    end

    assign rd_mag   = q_rd_reg.mag;
    assign rd_sq    = q_rd_reg.sq;
    assign rd_agree = (s_rd_reg[bit_reg] == q_rd_reg.sign);

endmodule

>>> rtl/core/haar_level_distance_bounds.sv
// Top level of the Haar level distance bounds block: sequencer and state.
// Depends on hldb_pkg, hldb_store, hldb_mul and hldb_sqrt.
//
// Usage: drive opcode and its fields with start high; a request is taken at
// a rising edge where start is high and busy is low. Opcodes 0 to 3 (query
// entry, level, candidate sums, sign word) and the unused codes complete in
// the accepting cycle and leave busy low. A coefficient (opcode 4) holds busy
// for a read step, two passes of the shared multiplier and a step to advance
// the position; the product pass is skipped when its entry lies beyond the
// vector size. A coefficient marked last then closes the level with four
// multiplier passes and three passes of the square root unit plus the walk:
// each walked span takes two multiplier passes and a read and an accumulate
// step per query entry. Level 0 walks the spans from 2 upward, doubling while
// below the vector size, plus a final check to stop; other levels walk one
// span. The result is shown for exactly one cycle with done high; the
// receiver cannot stall it, and busy is already low in that cycle.
// vector_size_wdata is written when vector_size_we is high; the user must
// write it only while idle, and the block itself does not enforce this.
// Reset clears the candidate, level and coefficient sums and the level
// registers and sets vector_size to 256; query and sign memories hold nothing
// defined until written, and need no clearing pass.
module haar_level_distance_bounds #(
    parameter int SIZE = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          opcode,
    input  logic [7:0]          index,
    input  logic signed [63:0]  first_value,
    input  logic signed [63:0]  second_value,
    input  logic signed [63:0]  third_value,
    input  logic signed [63:0]  fourth_value,
    input  logic signed [63:0]  fifth_value,
    input  logic [31:0]         sign_word,
    input  logic [3:0]          level,
    input  logic [7:0]          level_start,
    input  logic                last,
    input  logic                vector_size_we,
    input  logic [8:0]          vector_size_wdata,
    output logic                done,
    output logic signed [63:0]  distance_out,
    output logic signed [63:0]  weighted_energy_out,
    output logic signed [63:0]  remaining_energy_out,
    output logic [62:0]         odd_sum_out,
    output logic [62:0]         even_sum_out,
    output logic signed [63:0]  upper_bound,
    output logic signed [63:0]  lower_bound
);
    import hldb_pkg::*;

    localparam int SW = (SIZE + 31) / 32;

    typedef enum logic [22:0] {
        ST_IDLE   = 23'h000001,
        ST_C_RD   = 23'h000002,
        ST_C_SQ   = 23'h000004,
        ST_C_PR   = 23'h000008,
        ST_C_END  = 23'h000010,
        ST_CL_D   = 23'h000020,
        ST_CL_M1S = 23'h000040,
        ST_CL_M1  = 23'h000080,
        ST_CL_M2  = 23'h000100,
        ST_CL_SQ  = 23'h000200,
        ST_W_INIT = 23'h000400,
        ST_W_RD   = 23'h000800,
        ST_W_ACC  = 23'h001000,
        ST_W_MO   = 23'h002000,
        ST_W_ME   = 23'h004000,
        ST_CLAMP  = 23'h008000,
        ST_SQ_O_S = 23'h010000,
        ST_SQ_O   = 23'h020000,
        ST_M_U    = 23'h040000,
        ST_SQ_E   = 23'h080000,
        ST_M_L    = 23'h100000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]         vs_reg, vs_next;
    logic signed [63:0] rd_reg, rd_next, we_reg, we_next, re_reg, re_next;
    logic signed [63:0] odd_reg, odd_next, even_reg, even_next;
    logic [3:0]         lvl_reg, lvl_next;
    logic [7:0]         ls_reg, ls_next, pos_reg, pos_next;
    logic signed [63:0] lqs_reg, lqs_next, ols_reg, ols_next;
    logic signed [63:0] lw_reg, lw_next, lws_reg, lws_next;
    logic signed [63:0] ea_reg, ea_next, pa_reg, pa_next;
    logic signed [63:0] v1_reg, v1_next, d_reg, d_next;
    logic signed [63:0] com_reg, com_next, f_reg, f_next;
    logic signed [63:0] so_reg, so_next, se_reg, se_next;
    logic signed [63:0] up_reg, up_next, lo_reg, lo_next;
    logic [44:0]        t_reg, t_next;
    logic [62:0]        mag_reg, mag_next;
    logic               agree_reg, agree_next, last_reg, last_next;
    logic               inr_reg, inr_next, done_reg, done_next;
    logic [9:0]         c_reg, c_next, wj_reg, wj_next;

    logic               accept, lvl0;
    logic [9:0]         eff, j_coef, wfrom, wto, rd_addr;
    logic signed [63:0] fac;
    logic               q_we, s_we;
    q_entry_t           q_wdata;
    logic [63:0]        qm;
    logic [62:0]        rd_mag;
    logic signed [63:0] rd_sq;
    logic               rd_agree;
    logic               mul_start, mul_done, sqrt_start, sqrt_done;
    logic signed [63:0] mul_a, mul_b, mul_res, sqrt_x;
    logic [43:0]        sqrt_root;

    hldb_store #(.SIZE(SIZE)) u_store (
        .clk      (clk),
        .q_we     (q_we),
        .q_waddr  (index),
        .q_wdata  (q_wdata),
        .s_we     (s_we),
        .s_waddr  (index),
        .s_wdata  (sign_word),
        .rd_addr  (rd_addr),
        .rd_mag   (rd_mag),
        .rd_sq    (rd_sq),
        .rd_agree (rd_agree)
    );

    hldb_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    hldb_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (sqrt_x),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Derive sizes, addresses and the walk window
    always_comb
    begin
        accept  = start && (state_reg == ST_IDLE);
        lvl0    = (lvl_reg == 4'd0);
        eff     = (32'(vs_reg) < SIZE) ? 10'(vs_reg) : 10'(SIZE);
        j_coef  = {2'b00, ls_reg} + {2'b00, pos_reg};
        wfrom   = lvl0 ? c_reg : {2'b00, ls_reg};
        wto     = lvl0 ? {c_reg[8:0], 1'b0} : {1'b0, ls_reg, 1'b0};
        fac     = lvl0 ? f_reg : lws_reg;
        qm      = mag64(first_value);
        q_wdata.sign = sign_word[0];
        q_wdata.sq   = second_value;
        q_wdata.mag  = qm[63] ? {63{1'b1}} : qm[62:0];
        q_we    = accept && (opcode == OP_QUERY) && (32'(index) < SIZE);
        s_we    = accept && (opcode == OP_SIGN) && (32'(index) < SW);
    end

    // Sequence one request through the shared units
    always_comb
    begin
        state_next = state_reg;
        vs_next    = vs_reg;
        rd_next    = rd_reg;
        we_next    = we_reg;
        re_next    = re_reg;
        odd_next   = odd_reg;
        even_next  = even_reg;
        lvl_next   = lvl_reg;
        ls_next    = ls_reg;
        pos_next   = pos_reg;
        lqs_next   = lqs_reg;
        ols_next   = ols_reg;
        lw_next    = lw_reg;
        lws_next   = lws_reg;
        ea_next    = ea_reg;
        pa_next    = pa_reg;
        v1_next    = v1_reg;
        d_next     = d_reg;
        com_next   = com_reg;
        f_next     = f_reg;
        so_next    = so_reg;
        se_next    = se_reg;
        up_next    = up_reg;
        lo_next    = lo_reg;
        t_next     = t_reg;
        mag_next   = mag_reg;
        agree_next = agree_reg;
        last_next  = last_reg;
        inr_next   = inr_reg;
        c_next     = c_reg;
        wj_next    = wj_reg;
        done_next  = 1'b0;
        rd_addr    = wj_reg;
        mul_start  = 1'b0;
        mul_a      = v1_reg;
        mul_b      = v1_reg;
        sqrt_start = 1'b0;
        sqrt_x     = re_reg;

        if (vector_size_we)
            vs_next = vector_size_wdata;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = j_coef;
                if (accept)
                begin
                    case (opcode)
                        OP_LEVEL:
                        begin
                            lvl_next = level;
                            ls_next  = level_start;
                            lqs_next = first_value;
                            ols_next = second_value;
                            lw_next  = third_value;
                            lws_next = fourth_value;
                            ea_next  = 64'sd0;
                            pa_next  = 64'sd0;
                            pos_next = 8'd0;
                        end
                        OP_CAND:
                        begin
                            rd_next   = first_value;
                            we_next   = second_value;
                            re_next   = third_value;
                            odd_next  = fourth_value;
                            even_next = fifth_value;
                            ea_next   = 64'sd0;
                            pa_next   = 64'sd0;
                            pos_next  = 8'd0;
                        end
                        OP_COEF:
                        begin
                            v1_next    = first_value;
                            last_next  = last;
                            inr_next   = (j_coef < eff);
                            state_next = ST_C_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_C_RD:
            begin
                mag_next   = rd_mag;
                agree_next = rd_agree;
                mul_start  = 1'b1;
                state_next = ST_C_SQ;
            end
            ST_C_SQ:
            begin
                mul_a = v1_reg;
                mul_b = {1'b0, mag_reg};
                if (mul_done)
                begin
                    ea_next = sat_add(ea_reg, mul_res);
                    if (inr_reg)
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_C_PR;
                    end
                    else
                        state_next = ST_C_END;
                end
            end
            ST_C_PR:
            begin
                if (mul_done)
                begin
                    pa_next    = agree_reg ? sat_add(pa_reg, mul_res)
                                           : sat_sub(pa_reg, mul_res);
                    state_next = ST_C_END;
                end
            end
            ST_C_END:
            begin
                pos_next   = pos_reg + 8'd1;
                state_next = last_reg ? ST_CL_D : ST_IDLE;
            end
            ST_CL_D:
            begin
                d_next     = sat_sub(sat_add(ea_reg, lqs_reg), sat_add(pa_reg, pa_reg));
                re_next    = sat_sub(re_reg, ea_reg);
                state_next = ST_CL_M1S;
            end
            ST_CL_M1S:
            begin
                mul_a      = lw_reg;
                mul_b      = d_reg;
                mul_start  = 1'b1;
                state_next = ST_CL_M1;
            end
            ST_CL_M1:
            begin
                mul_a = ea_reg;
                mul_b = lw_reg;
                if (mul_done)
                begin
                    rd_next    = sat_add(rd_reg, mul_res);
                    mul_start  = 1'b1;
                    state_next = ST_CL_M2;
                end
            end
            ST_CL_M2:
            begin
                sqrt_x = re_reg;
                if (mul_done)
                begin
                    we_next    = sat_sub(we_reg, mul_res);
                    sqrt_start = 1'b1;
                    state_next = ST_CL_SQ;
                end
            end
            ST_CL_SQ:
            begin
                if (sqrt_done)
                begin
                    t_next     = {sqrt_root, 1'b0};
                    com_next   = sat_add(sat_add(rd_reg, we_reg), ols_reg);
                    f_next     = quarter_int(lws_reg);
                    c_next     = 10'd2;
                    state_next = ST_W_INIT;
                end
            end
            ST_W_INIT:
            begin
                so_next = 64'sd0;
                se_next = 64'sd0;
                wj_next = wfrom;
                if (lvl0 && !(c_reg < eff))
                    state_next = ST_CLAMP;
                else
                    state_next = ST_W_RD;
            end
            ST_W_RD:
            begin
                mul_a = so_reg;
                mul_b = fac;
                if (wj_reg < wto && wj_reg < eff)
                    state_next = ST_W_ACC;
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_W_MO;
                end
            end
            ST_W_ACC:
            begin
                if (rd_agree)
                    se_next = sat_add(se_reg, rd_sq);
                else
                    so_next = sat_add(so_reg, rd_sq);
                wj_next    = wj_reg + 10'd1;
                state_next = ST_W_RD;
            end
            ST_W_MO:
            begin
                mul_a = se_reg;
                mul_b = fac;
                if (mul_done)
                begin
                    odd_next   = lvl0 ? sat_add(odd_reg, mul_res) : sat_sub(odd_reg, mul_res);
                    mul_start  = 1'b1;
                    state_next = ST_W_ME;
                end
            end
            ST_W_ME:
            begin
                if (mul_done)
                begin
                    if (lvl0)
                    begin
                        even_next  = sat_add(even_reg, mul_res);
                        f_next     = quarter_int(f_reg);
                        c_next     = {c_reg[8:0], 1'b0};
                        state_next = ST_W_INIT;
                    end
                    else
                    begin
                        even_next  = sat_sub(even_reg, mul_res);
                        state_next = ST_CLAMP;
                    end
                end
            end
            ST_CLAMP:
            begin
                if (odd_reg[63])
                    odd_next = 64'sd0;
                if (even_reg[63])
                    even_next = 64'sd0;
                state_next = ST_SQ_O_S;
            end
            ST_SQ_O_S:
            begin
                sqrt_x     = odd_reg;
                sqrt_start = 1'b1;
                state_next = ST_SQ_O;
            end
            ST_SQ_O:
            begin
                mul_a = {19'd0, t_reg};
                mul_b = {20'd0, sqrt_root};
                if (sqrt_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_M_U;
                end
            end
            ST_M_U:
            begin
                sqrt_x = even_reg;
                if (mul_done)
                begin
                    up_next    = sat_add(com_reg, mul_res);
                    sqrt_start = 1'b1;
                    state_next = ST_SQ_E;
                end
            end
            ST_SQ_E:
            begin
                mul_a = {19'd0, t_reg};
                mul_b = {20'd0, sqrt_root};
                if (sqrt_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_M_L;
                end
            end
            ST_M_L:
            begin
                if (mul_done)
                begin
                    lo_next    = sat_sub(com_reg, mul_res);
                    done_next  = 1'b1;
                    ea_next    = 64'sd0;
                    pa_next    = 64'sd0;
                    pos_next   = 8'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and the candidate and level sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vs_reg    <= 9'd256;
            rd_reg    <= 64'sd0;
            we_reg    <= 64'sd0;
            re_reg    <= 64'sd0;
            odd_reg   <= 64'sd0;
            even_reg  <= 64'sd0;
            lvl_reg   <= 4'd0;
            ls_reg    <= 8'd0;
            pos_reg   <= 8'd0;
            lqs_reg   <= 64'sd0;
            ols_reg   <= 64'sd0;
            lw_reg    <= 64'sd0;
            lws_reg   <= 64'sd0;
            ea_reg    <= 64'sd0;
            pa_reg    <= 64'sd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vs_reg    <= vs_next;
            rd_reg    <= rd_next;
            we_reg    <= we_next;
            re_reg    <= re_next;
            odd_reg   <= odd_next;
            even_reg  <= even_next;
            lvl_reg   <= lvl_next;
            ls_reg    <= ls_next;
            pos_reg   <= pos_next;
            lqs_reg   <= lqs_next;
            ols_reg   <= ols_next;
            lw_reg    <= lw_next;
            lws_reg   <= lws_next;
            ea_reg    <= ea_next;
            pa_reg    <= pa_next;
            done_reg  <= done_next;
        end
    end

    // Working values of the current request
    always_ff @(posedge clk)
    begin
        v1_reg    <= v1_next;
        d_reg     <= d_next;
        com_reg   <= com_next;
        f_reg     <= f_next;
        so_reg    <= so_next;
        se_reg    <= se_next;
        up_reg    <= up_next;
        lo_reg    <= lo_next;
        t_reg     <= t_next;
        mag_reg   <= mag_next;
        agree_reg <= agree_next;
        last_reg  <= last_next;
        inr_reg   <= inr_next;
        c_reg     <= c_next;
        wj_reg    <= wj_next;
    end

    assign busy                 = (state_reg != ST_IDLE);
    assign done                 = done_reg;
    assign distance_out         = rd_reg;
    assign weighted_energy_out  = we_reg;
    assign remaining_energy_out = re_reg;
    assign odd_sum_out          = odd_reg[62:0];
    assign even_sum_out         = even_reg[62:0];
    assign upper_bound          = up_reg;
    assign lower_bound          = lo_reg;

endmodule
